// File: rtl/core/snrt_pkg.sv
// Shared constants, types and codes of the slot and node reservation table.
package snrt_pkg;

  localparam int NODES       = 16;
  localparam int SLOTS       = 16;
  localparam int NODE_W      = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OWNER_W     = 16;
  localparam int CNT_W       = 32;
  localparam int HOUR_W      = 5;
  localparam int SLOT_HOUR_W = 6;
  localparam int NODE_OUT_W  = 4;
  localparam int STATUS_W    = 3;

  localparam logic [HOUR_W-1:0] HOUR_START_RESET = HOUR_W'(8);

  localparam logic REQ_RESERVE = 1'b0;
  localparam logic REQ_CANCEL  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_RESERVED  = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_PENALTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RES_NODE,
    S_RES_SLOT,
    S_RES_SUCC,
    S_FAIL,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef logic [NODES-1:0][OWNER_W-1:0] owner_row_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [NODE_W-1:0]  lane;
    logic [OWNER_W-1:0] data;
  } owner_wr_t;

endpackage

// File: rtl/core/snrt_if.sv
// Handshake channel interfaces for configuration, requests and results.
interface snrt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [snrt_pkg::HOUR_W-1:0] hour_start;

  modport source (output valid, output hour_start, input ready);
  modport sink (input valid, input hour_start, output ready);
endinterface

interface snrt_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [snrt_pkg::OWNER_W-1:0] user_id;
  logic [snrt_pkg::HOUR_W-1:0]  hour;

  modport source (output valid, output req_type, output user_id, output hour, input ready);
  modport sink (input valid, input req_type, input user_id, input hour, output ready);
endinterface

interface snrt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [snrt_pkg::STATUS_W-1:0]    status;
  logic [snrt_pkg::NODE_OUT_W-1:0]  node_index;
  logic [snrt_pkg::SLOT_HOUR_W-1:0] slot_hour;
  logic [snrt_pkg::CNT_W-1:0]       node_use_total;
  logic [snrt_pkg::CNT_W-1:0]       success_total;
  logic [snrt_pkg::CNT_W-1:0]       failure_total;

  modport source (output valid, output status, output node_index, output slot_hour,
                  output node_use_total, output success_total, output failure_total,
                  input ready);
  modport sink (input valid, input status, input node_index, input slot_hour,
                input node_use_total, input success_total, input failure_total,
                output ready);
endinterface

// File: rtl/core/snrt_owner_ram.sv
// Owner memory: one row of node owners per slot, lane write, registered row read.
module snrt_owner_ram (
  input  logic                        clk,
  input  snrt_pkg::owner_wr_t         wr,
  input  logic                        rd_en,
  input  logic [snrt_pkg::SLOT_W-1:0] rd_addr,
  output snrt_pkg::owner_row_t        rd_data
);
  import snrt_pkg::*;

  owner_row_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot][wr.lane] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/snrt_row_match.sv
// Compares every owner of one slot row against the requesting user.
module snrt_row_match (
  input  snrt_pkg::owner_row_t         row,
  input  logic [snrt_pkg::NODES-1:0]   taken,
  input  logic [snrt_pkg::OWNER_W-1:0] user,
  output logic [snrt_pkg::NODES-1:0]   match
);
  import snrt_pkg::*;

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      match[i] = taken[i] && (row[i] == user);
    end
  end

endmodule

// File: rtl/core/snrt_pick.sv
// Picks the lowest set bit of a node candidate mask.
module snrt_pick (
  input  logic [snrt_pkg::NODES-1:0]  cand,
  output logic                        any,
  output logic [snrt_pkg::NODE_W-1:0] idx
);
  import snrt_pkg::*;

  always_comb begin
    idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = NODE_W'(i);
      end
    end
    any = |cand;
  end

endmodule

// File: rtl/core/slot_node_reservation_table.sv
// Top level of the slot and node reservation table with its request sequencer.
// A reservation steps through S_CHECK, S_RES_NODE, S_RES_SLOT and S_RES_SUCC to S_EMIT;
// a full slot goes S_CHECK, S_FAIL, S_EMIT, an hour outside the window S_CHECK, S_EMIT,
// and a cancel scans in S_SCAN (one owner row read per cycle from the owner RAM).
// One request at a time: the next is taken once the result is in the output register.
// Reset (rst, synchronous): every entry free, all counters zero, hour_start 8.
module slot_node_reservation_table (
  input logic       clk,
  input logic       rst,
  snrt_cfg_if.sink  cfg,
  snrt_req_if.sink  req,
  snrt_rsp_if.source rsp
);
  import snrt_pkg::*;

  // Sequencer state.
  state_t state, state_next;

  // Configuration register.
  logic [HOUR_W-1:0] hour_start;

  // Request held for the duration of its work.
  logic [OWNER_W-1:0] user_q;
  logic [HOUR_W-1:0]  hour_q;

  // Free bits, one flop per entry, so reset frees the whole table at once.
  logic [NODES-1:0] free_q [SLOTS];

  // Counters.
  logic [CNT_W-1:0] node_use [NODES];
  logic [CNT_W-1:0] slot_cnt [SLOTS];
  logic [CNT_W-1:0] success_cnt;
  logic [CNT_W-1:0] failure_cnt;

  // Result being built.
  logic [SLOT_W-1:0]      slot_q;
  logic [NODE_W-1:0]      node_q;
  status_t                status_q;
  logic [SLOT_HOUR_W-1:0] slot_hour_q;
  logic [CNT_W-1:0]       use_q;

  // Cancel scan: the read pointer runs one row ahead of the compare.
  logic [SLOT_W-1:0] scan_rd;
  logic              rd_done;
  logic [SLOT_W-1:0] cmp_slot_q;
  logic              cmp_valid_q;

  // Output register.
  logic                  out_valid;
  status_t               out_status;
  logic [NODE_W-1:0]     out_node;
  logic [SLOT_HOUR_W-1:0] out_slot_hour;
  logic [CNT_W-1:0]      out_use;
  logic [CNT_W-1:0]      out_success;
  logic [CNT_W-1:0]      out_failure;

  // Datapath wires.
  logic [SLOT_HOUR_W-1:0] hs_ext;
  logic [SLOT_HOUR_W-1:0] hr_ext;
  logic [SLOT_HOUR_W-1:0] hour_diff;
  logic                   in_window;
  logic [SLOT_W-1:0]      win_slot;
  owner_row_t             owner_row;
  owner_wr_t              owner_wr;
  logic                   rd_en;
  logic [NODES-1:0]       match_mask;
  logic [NODES-1:0]       pick_cand;
  logic                   pick_any;
  logic [NODE_W-1:0]      pick_idx;
  logic                   hit;
  logic                   scan_miss;
  logic                   emit_load;
  logic [CNT_W-1:0]       add_in;
  logic [CNT_W-1:0]       add_sum;

  // Window check: hour_start + SLOTS may run past the day, so the compare is done
  // one bit wider than an hour.
  assign hs_ext    = SLOT_HOUR_W'(hour_start);
  assign hr_ext    = SLOT_HOUR_W'(hour_q);
  assign hour_diff = hr_ext - hs_ext;
  assign in_window = (hr_ext >= hs_ext) && (hr_ext < hs_ext + SLOT_HOUR_W'(SLOTS));
  assign win_slot  = hour_diff[SLOT_W-1:0];

  // Owner storage. A reservation writes one lane; a cancel only sets the free bit,
  // because an owner is never looked at while its entry is free.
  always_comb begin
    owner_wr.en   = (state == S_CHECK) && in_window && pick_any;
    owner_wr.slot = win_slot;
    owner_wr.lane = pick_idx;
    owner_wr.data = user_q;
  end

  assign rd_en = (state == S_SCAN) && !rd_done;

  snrt_owner_ram u_owner_ram (
    .clk     (clk),
    .wr      (owner_wr),
    .rd_en   (rd_en),
    .rd_addr (scan_rd),
    .rd_data (owner_row)
  );

  snrt_row_match u_row_match (
    .row   (owner_row),
    .taken (~free_q[cmp_slot_q]),
    .user  (user_q),
    .match (match_mask)
  );

  // The one priority picker serves both the lowest free node of a reservation and
  // the first matching node of a cancel.
  assign pick_cand = (state == S_SCAN) ? match_mask : free_q[win_slot];

  snrt_pick u_pick (
    .cand (pick_cand),
    .any  (pick_any),
    .idx  (pick_idx)
  );

  assign hit       = (state == S_SCAN) && cmp_valid_q && pick_any;
  assign scan_miss = (state == S_SCAN) && rd_done && !cmp_valid_q;
  assign emit_load = (state == S_EMIT) && (!out_valid || rsp.ready);

  // Shared incrementer: each counter is bumped in a state of its own.
  always_comb begin
    case (state)
      S_RES_NODE: add_in = node_use[node_q];
      S_RES_SLOT: add_in = slot_cnt[slot_q];
      S_RES_SUCC: add_in = success_cnt;
      S_FAIL:     add_in = failure_cnt;
      default:    add_in = '0;
    endcase
  end

  assign add_sum = add_in + CNT_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.req_type == REQ_CANCEL) ? S_SCAN : S_CHECK;
        end
      end
      S_CHECK: begin
        if (!in_window) begin
          state_next = S_EMIT;
        end else if (!pick_any) begin
          state_next = S_FAIL;
        end else begin
          state_next = S_RES_NODE;
        end
      end
      S_RES_NODE: state_next = S_RES_SLOT;
      S_RES_SLOT: state_next = S_RES_SUCC;
      S_RES_SUCC: state_next = S_EMIT;
      S_FAIL:     state_next = S_EMIT;
      S_SCAN: begin
        if (hit || scan_miss) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration: the port is always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_start <= HOUR_START_RESET;
    end else if (cfg.valid) begin
      hour_start <= cfg.hour_start;
    end
  end

  // Table state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        free_q[s]   <= '1;
        slot_cnt[s] <= '0;
      end
      for (int n = 0; n < NODES; n++) begin
        node_use[n] <= '0;
      end
      success_cnt <= '0;
      failure_cnt <= '0;
      rd_done     <= 1'b0;
      cmp_valid_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_done     <= 1'b0;
          cmp_valid_q <= 1'b0;
        end
        S_CHECK: begin
          if (in_window && pick_any) begin
            free_q[win_slot][pick_idx] <= 1'b0;
          end
        end
        S_RES_NODE: node_use[node_q] <= add_sum;
        S_RES_SLOT: slot_cnt[slot_q] <= add_sum;
        S_RES_SUCC: success_cnt      <= add_sum;
        S_FAIL:     failure_cnt      <= add_sum;
        S_SCAN: begin
          cmp_valid_q <= !rd_done;
          if (!rd_done && (scan_rd == SLOT_W'(SLOTS - 1))) begin
            rd_done <= 1'b1;
          end
          if (hit) begin
            free_q[cmp_slot_q][pick_idx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request capture, scan pointers and the result under construction.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          user_q <= req.user_id;
          hour_q <= req.hour;
        end
        scan_rd <= '0;
      end
      S_CHECK: begin
        slot_q <= win_slot;
        use_q  <= '0;
        if (!in_window) begin
          status_q    <= ST_OUTSIDE;
          node_q      <= '0;
          slot_hour_q <= '0;
        end else if (!pick_any) begin
          status_q    <= ST_FULL;
          node_q      <= '0;
          slot_hour_q <= '0;
        end else begin
          status_q    <= ST_RESERVED;
          node_q      <= pick_idx;
          slot_hour_q <= hr_ext;
        end
      end
      S_RES_NODE: use_q <= add_sum;
      S_SCAN: begin
        if (!rd_done) begin
          scan_rd <= scan_rd + SLOT_W'(1);
        end
        cmp_slot_q <= scan_rd;
        if (hit) begin
          status_q    <= ST_CANCELLED;
          node_q      <= pick_idx;
          slot_hour_q <= hs_ext + SLOT_HOUR_W'(cmp_slot_q);
          use_q       <= node_use[pick_idx];
        end else if (scan_miss) begin
          status_q    <= ST_PENALTY;
          node_q      <= '0;
          slot_hour_q <= '0;
          use_q       <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here while the next request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_status    <= status_q;
      out_node      <= node_q;
      out_slot_hour <= slot_hour_q;
      out_use       <= use_q;
      out_success   <= success_cnt;
      out_failure   <= failure_cnt;
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.node_index     = NODE_OUT_W'(out_node);
  assign rsp.slot_hour      = out_slot_hour;
  assign rsp.node_use_total = out_use;
  assign rsp.success_total  = out_success;
  assign rsp.failure_total  = out_failure;

endmodule

// File: rtl/core/snrt_checker.sv
// Port-level checker for the reservation table, bound to the top level.
module snrt_port_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input logic [snrt_pkg::STATUS_W-1:0]        rsp_status,
  input logic [snrt_pkg::NODE_OUT_W-1:0]      rsp_node_index,
  input logic [snrt_pkg::SLOT_HOUR_W-1:0]     rsp_slot_hour,
  input logic [snrt_pkg::CNT_W-1:0]           rsp_node_use_total
);
  import snrt_pkg::*;

  // A result that is not taken stays on the port.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("result changed while stalled");

  // Reset leaves the block ready with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("block not idle after reset");

  // A request occupies the block for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is still at work");

  // Refused and penalty results report no node.
  a_no_node_on_refusal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_OUTSIDE || rsp_status == ST_FULL ||
                  rsp_status == ST_PENALTY)
    |-> rsp_node_index == '0 && rsp_slot_hour == '0 && rsp_node_use_total == '0)
    else $error("node reported with a refusal status");

endmodule

bind slot_node_reservation_table snrt_port_checker u_snrt_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_node_index     (rsp.node_index),
  .rsp_slot_hour      (rsp.slot_hour),
  .rsp_node_use_total (rsp.node_use_total)
);

// File: test/snrt_checker.sv
// Checker for the reservation table: watches the channels, predicts each result and compares it.
module snrt_checker (
  input  logic        clk,
  input  logic        rst,
  snrt_cfg_if         cfg,
  snrt_req_if         req,
  snrt_rsp_if         rsp,
  output int unsigned pending,
  output int unsigned errors,
  output int unsigned outcome_count [5]
);
  import snrt_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [NODE_OUT_W-1:0]  node_index;
    logic [SLOT_HOUR_W-1:0] slot_hour;
    logic [CNT_W-1:0]       node_use_total;
    logic [CNT_W-1:0]       success_total;
    logic [CNT_W-1:0]       failure_total;
  } outcome_t;

  logic [HOUR_W-1:0]  window_start;
  logic               slot_free  [SLOTS][NODES];
  logic [OWNER_W-1:0] slot_owner [SLOTS][NODES];
  logic [CNT_W-1:0]   node_uses  [NODES];
  logic [CNT_W-1:0]   granted;
  logic [CNT_W-1:0]   refused;
  outcome_t           awaited_outcomes [$];

  // Applies one request to the table copy and returns the result it must produce.
  function automatic outcome_t resolve_request(logic kind, logic [OWNER_W-1:0] user,
                                               logic [HOUR_W-1:0] hour);
    outcome_t o;
    int       s;
    bit       done;
    o    = '0;
    done = 1'b0;
    if (kind == REQ_RESERVE) begin
      if (int'(hour) < int'(window_start) || int'(hour) >= int'(window_start) + SLOTS) begin
        o.status = ST_OUTSIDE;
      end else begin
        s = int'(hour) - int'(window_start);
        for (int n = 0; n < NODES; n++) begin
          if (!done && slot_free[s][n]) begin
            done             = 1'b1;
            slot_free[s][n]  = 1'b0;
            slot_owner[s][n] = user;
            node_uses[n]     = node_uses[n] + 1;
            granted          = granted + 1;
            o.status         = ST_RESERVED;
            o.node_index     = NODE_OUT_W'(n);
            o.slot_hour      = SLOT_HOUR_W'(hour);
            o.node_use_total = node_uses[n];
          end
        end
        if (!done) begin
          refused  = refused + 1;
          o.status = ST_FULL;
        end
      end
    end else begin
      for (int sl = 0; sl < SLOTS; sl++) begin
        for (int n = 0; n < NODES; n++) begin
          if (!done && !slot_free[sl][n] && slot_owner[sl][n] == user) begin
            done             = 1'b1;
            slot_free[sl][n] = 1'b1;
            o.status         = ST_CANCELLED;
            o.node_index     = NODE_OUT_W'(n);
            o.slot_hour      = SLOT_HOUR_W'(int'(window_start) + sl);
            o.node_use_total = node_uses[n];
          end
        end
      end
      if (!done) o.status = ST_PENALTY;
    end
    o.success_total = granted;
    o.failure_total = refused;
    return o;
  endfunction

  function automatic void compare_field(string field, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      window_start = HOUR_START_RESET;
      for (int sl = 0; sl < SLOTS; sl++) begin
        for (int n = 0; n < NODES; n++) slot_free[sl][n] = 1'b1;
      end
      for (int n = 0; n < NODES; n++) node_uses[n] = '0;
      granted = '0;
      refused = '0;
      awaited_outcomes.delete();
    end else begin
      if (cfg.valid && cfg.ready) window_start = cfg.hour_start;
      // The result leaving now belongs to an earlier request, so it is matched first.
      if (rsp.valid && rsp.ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          compare_field("status", CNT_W'(want.status), CNT_W'(rsp.status));
          compare_field("node_index", CNT_W'(want.node_index), CNT_W'(rsp.node_index));
          compare_field("slot_hour", CNT_W'(want.slot_hour), CNT_W'(rsp.slot_hour));
          compare_field("node_use_total", want.node_use_total, rsp.node_use_total);
          compare_field("success_total", want.success_total, rsp.success_total);
          compare_field("failure_total", want.failure_total, rsp.failure_total);
          outcome_count[int'(want.status)]++;
        end
      end
      if (req.valid && req.ready)
        awaited_outcomes.push_back(resolve_request(req.req_type, req.user_id, req.hour));
    end
    pending <= awaited_outcomes.size();
  end

endmodule

// File: test/tb.sv
// Top of the reservation table regression: clock, reset, stimulus, output stalls and verdict.
module tb;
  import snrt_pkg::*;

  // The settling pause leaves a margin above the longest cancel scan.
  localparam int unsigned SETTLE_CYCLES  = SLOTS + 8;
  // The long result stall must stay well below the watchdog limit.
  localparam int unsigned LONG_STALL     = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SEG_ITEMS      = 155;
  localparam int unsigned POOL_SIZE      = 8;

  logic clk;
  logic rst;

  snrt_cfg_if cfg_ch ();
  snrt_req_if req_ch ();
  snrt_rsp_if rsp_ch ();

  int unsigned pending;
  int unsigned errors;
  int unsigned outcome_count [5];

  // Percentages of cycles in which the sender and the receiver hold back.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        stall_req;

  int unsigned        reserves_sent;
  int unsigned        cancels_sent;
  int unsigned        windows_used;
  logic [OWNER_W-1:0] user_pool [POOL_SIZE];

  slot_node_reservation_table DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  snrt_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .pending       (pending),
    .errors        (errors),
    .outcome_count (outcome_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver. It normally lowers ready at random; once the stimulus asks for it, it holds
  // ready low for a long stretch so that the result register fills and the block refuses
  // further request transfers. The stretch is counted here, independently of the sender.
  initial begin
    int unsigned held;
    bit          stalled_once;
    held         = 0;
    stalled_once = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && !stalled_once) begin
        rsp_ch.ready <= 1'b0;
        held++;
        if (held == LONG_STALL) stalled_once = 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // The watchdog ends the run when no transfer of any kind has happened for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("slot_node_reservation_table regression: fail");
    $finish;
  end

  // Offers one request, with random idle cycles in front of it, and returns once the
  // transfer has happened. Valid stays high when the next request follows straight away.
  task automatic offer_request(logic kind, logic [OWNER_W-1:0] user, logic [HOUR_W-1:0] hour);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.user_id  <= user;
    req_ch.hour     <= hour;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == REQ_RESERVE) reserves_sent++;
    else cancels_sent++;
  endtask

  // Waits until every predicted result has arrived, then lets the block settle to idle.
  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Moves the window; only ever called while the block is idle.
  task automatic set_window_start(logic [HOUR_W-1:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.hour_start <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    windows_used++;
  endtask

  // A run of random requests. Most users come from a small pool so that cancels find
  // entries, and most reserve hours fall on two hot slots so that those slots fill up.
  task automatic run_segment(logic [HOUR_W-1:0] start, int unsigned reserve_pct);
    logic [HOUR_W-1:0]  hour;
    logic [OWNER_W-1:0] user;
    for (int i = 0; i < SEG_ITEMS; i++) begin
      user = ($urandom_range(99) < 85) ? user_pool[$urandom_range(POOL_SIZE - 1)]
                                       : OWNER_W'($urandom);
      case ($urandom_range(9))
        0, 1:    hour = HOUR_W'($urandom);
        2, 3, 4: hour = start + HOUR_W'($urandom_range(SLOTS - 1));
        default: hour = start + HOUR_W'($urandom_range(1));
      endcase
      offer_request(($urandom_range(99) < reserve_pct) ? REQ_RESERVE : REQ_CANCEL, user, hour);
    end
  endtask

  initial begin
    logic [HOUR_W-1:0] window;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_RESERVE;
    req_ch.user_id    <= '0;
    req_ch.hour       <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.hour_start <= HOUR_START_RESET;
    stall_req         <= 1'b0;
    tx_idle_pct       <= 35;
    rx_idle_pct       <= 52;
    reserves_sent     = 0;
    cancels_sent      = 0;
    windows_used      = 1;
    // The pool holds the all-zero and all-one users beside random ones.
    user_pool[0] = '0;
    user_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) user_pool[i] = OWNER_W'($urandom);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the window at its reset position. An empty table gives a penalty
    // on cancel; hours just below, just past and far past the window are refused.
    offer_request(REQ_CANCEL, 16'hBEEF, HOUR_START_RESET);
    offer_request(REQ_RESERVE, 16'h1111, HOUR_START_RESET - HOUR_W'(1));
    offer_request(REQ_RESERVE, 16'h2222, HOUR_W'(HOUR_START_RESET + SLOTS));
    offer_request(REQ_RESERVE, 16'h3333, '1);
    // Fill the first slot, with the all-one user on node 3 and the all-zero user on node 9,
    // and then ask once more so that the slot is found full.
    for (int n = 0; n <= NODES; n++)
      offer_request(REQ_RESERVE,
                    (n == 3) ? 16'hFFFF : (n == 9) ? 16'h0000 : OWNER_W'(16'h0100 + n),
                    HOUR_START_RESET);
    // The last slot of the window; cancels then take the first owned entry in scan order.
    offer_request(REQ_RESERVE, 16'hFFFF, HOUR_W'(HOUR_START_RESET + SLOTS - 1));
    offer_request(REQ_CANCEL, 16'hFFFF, '0);
    offer_request(REQ_CANCEL, 16'hFFFF, '1);
    offer_request(REQ_CANCEL, 16'h0000, '0);
    // The freed node 3 is again the lowest free one, and its use count has reached two.
    offer_request(REQ_RESERVE, 16'hAAAA, HOUR_START_RESET);
    drain_and_settle();

    // Random part: the sender idles less than the receiver at first.
    set_window_start(5'd0);
    run_segment(5'd0, 75);
    drain_and_settle();
    // A window start beyond the last hour of the day is taken as written.
    set_window_start(5'd31);
    run_segment(5'd31, 45);
    drain_and_settle();

    // Now the receiver idles less than the sender.
    tx_idle_pct <= 52;
    rx_idle_pct <= 35;
    set_window_start(5'd23);
    run_segment(5'd23, 65);
    drain_and_settle();
    window = HOUR_W'($urandom_range(23));
    set_window_start(window);
    run_segment(window, 40);
    drain_and_settle();

    // Neither side idles, and the receiver takes its long stall in this stretch.
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    stall_req   <= 1'b1;
    set_window_start(HOUR_START_RESET);
    run_segment(HOUR_START_RESET, 80);
    drain_and_settle();
    window = HOUR_W'($urandom);
    set_window_start(window);
    run_segment(window, 50);
    drain_and_settle();

    $display("Covered %0d reserves and %0d cancels over %0d window settings,", reserves_sent,
             cancels_sent, windows_used);
    $display("giving %0d reserved, %0d outside, %0d full, %0d cancelled, %0d penalties.",
             outcome_count[ST_RESERVED], outcome_count[ST_OUTSIDE], outcome_count[ST_FULL],
             outcome_count[ST_CANCELLED], outcome_count[ST_PENALTY]);
    if (errors == 0)
      $display("slot_node_reservation_table regression: pass");
    else
      $display("slot_node_reservation_table regression: fail");
    $finish;
  end

endmodule
